### rtl/pisc_pkg.sv
package pisc_pkg;

    // Fixed-point and field widths
    localparam int GAIN_W      = 16;
    localparam int GAIN_FRAC   = 12;
    localparam int SAMPLE_W    = 16;
    localparam int THRUST_W    = 16;
    localparam int WINDOW_W    = 15;
    localparam int CLAMP_W     = 23;
    localparam int ERROR_W     = SAMPLE_W + 1;
    localparam int INTEG_W     = 24;
    localparam int DRIVE_W     = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 23;
    localparam int IN_TDATA_W  = 56;

    // Register reset values
    localparam logic [GAIN_W-1:0]   P_GAIN_RST     = 16'd6963;
    localparam logic [GAIN_W-1:0]   I_GAIN_RST     = 16'd82;
    localparam logic [GAIN_W-1:0]   D_GAIN_RST     = 16'd2458;
    localparam logic [WINDOW_W-1:0] WINDOW_RST     = 15'd150;
    localparam logic [CLAMP_W-1:0]  CLAMP_RST      = 23'd1200;
    localparam logic [THRUST_W-1:0] THRUST_THR_RST = 16'd180;

    // Register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_P_GAIN     = 3'd0,
        CFG_I_GAIN     = 3'd1,
        CFG_D_GAIN     = 3'd2,
        CFG_WINDOW     = 3'd3,
        CFG_CLAMP      = 3'd4,
        CFG_THRUST_THR = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0]   p_gain;
        logic [GAIN_W-1:0]   i_gain;
        logic [GAIN_W-1:0]   d_gain;
        logic [WINDOW_W-1:0] integral_window;
        logic [CLAMP_W-1:0]  integral_clamp;
        logic [THRUST_W-1:0] thrust_threshold;
    } t_cfg;

    typedef struct packed {
        logic [SAMPLE_W-1:0] target;
        logic [SAMPLE_W-1:0] measure;
        logic                armed;
        logic [THRUST_W-1:0] thrust;
    } t_item;

    typedef struct packed {
        logic [ERROR_W-1:0] previous_error;
        logic [INTEG_W-1:0] integral_sum;
        logic               integral_enable;
    } t_state;

endpackage

### rtl/pisc_cfg.sv
module pisc_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pisc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [pisc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output pisc_pkg::t_cfg                 o_cfg
);
    import pisc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Decode the write; unknown indexes leave everything as is
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_P_GAIN:     n_cfg.p_gain           = i_cfg_data[GAIN_W-1:0];
                CFG_I_GAIN:     n_cfg.i_gain           = i_cfg_data[GAIN_W-1:0];
                CFG_D_GAIN:     n_cfg.d_gain           = i_cfg_data[GAIN_W-1:0];
                CFG_WINDOW:     n_cfg.integral_window  = i_cfg_data[WINDOW_W-1:0];
                CFG_CLAMP:      n_cfg.integral_clamp   = i_cfg_data[CLAMP_W-1:0];
                CFG_THRUST_THR: n_cfg.thrust_threshold = i_cfg_data[THRUST_W-1:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.p_gain           <= P_GAIN_RST;
            r_cfg.i_gain           <= I_GAIN_RST;
            r_cfg.d_gain           <= D_GAIN_RST;
            r_cfg.integral_window  <= WINDOW_RST;
            r_cfg.integral_clamp   <= CLAMP_RST;
            r_cfg.thrust_threshold <= THRUST_THR_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

### rtl/pisc_calc.sv
module pisc_calc (
    input  pisc_pkg::t_cfg                  i_cfg,
    input  pisc_pkg::t_item                 i_item,
    input  pisc_pkg::t_state                i_state,
    output logic [pisc_pkg::DRIVE_W-1:0]    o_drive,
    output pisc_pkg::t_state                o_state
);
    import pisc_pkg::*;

    localparam int P_PROD_W = GAIN_W + ERROR_W;
    localparam int D_PROD_W = GAIN_W + ERROR_W + 1;
    localparam int I_PROD_W = GAIN_W + INTEG_W;
    localparam int SUM_W    = I_PROD_W - GAIN_FRAC + 1;
    localparam int ACC_W    = INTEG_W + 1;

    logic signed [ERROR_W-1:0]        error;
    logic signed [ERROR_W:0]          differ;
    logic signed [P_PROD_W-1:0]       p_prod;
    logic signed [D_PROD_W-1:0]       d_prod;
    logic signed [I_PROD_W-1:0]       i_prod;
    logic signed [SUM_W-1:0]          p_term;
    logic signed [SUM_W-1:0]          d_term;
    logic signed [SUM_W-1:0]          i_term;
    logic signed [SUM_W-1:0]          sum;
    logic signed [ERROR_W-1:0]        window_pos;
    logic signed [ERROR_W-1:0]        window_neg;
    logic signed [ACC_W-1:0]          acc;
    logic signed [ACC_W-1:0]          clamp_pos;
    logic signed [ACC_W-1:0]          clamp_neg;
    logic                             integrate;
    logic                             in_window;

    // Error and its change since the last word
    assign error  = $signed({i_item.target[SAMPLE_W-1], i_item.target})
                  - $signed({i_item.measure[SAMPLE_W-1], i_item.measure});
    assign differ = $signed({error[ERROR_W-1], error})
                  - $signed({i_state.previous_error[ERROR_W-1], i_state.previous_error});

    // Gain products; dropping the low fraction bits floors toward minus infinity
    assign p_prod = $signed(i_cfg.p_gain) * error;
    assign d_prod = $signed(i_cfg.d_gain) * differ;
    assign i_prod = $signed(i_cfg.i_gain) * $signed(i_state.integral_sum);

    assign p_term = SUM_W'($signed(p_prod[P_PROD_W-1:GAIN_FRAC]));
    assign d_term = SUM_W'($signed(d_prod[D_PROD_W-1:GAIN_FRAC]));
    assign i_term = i_state.integral_enable
                  ? SUM_W'($signed(i_prod[I_PROD_W-1:GAIN_FRAC])) : '0;

    // Term ranges keep the sum well inside 32 bits, so saturation reduces
    // to a sign extension
    assign sum     = p_term + i_term + d_term;
    assign o_drive = DRIVE_W'(sum);

    // Integral separation and clamp
    assign integrate  = i_item.armed && (i_item.thrust >= i_cfg.thrust_threshold);
    assign window_pos = $signed({2'b00, i_cfg.integral_window});
    assign window_neg = -window_pos;
    assign in_window  = ($signed({i_item.measure[SAMPLE_W-1], i_item.measure}) <= window_pos)
                     && ($signed({i_item.measure[SAMPLE_W-1], i_item.measure}) >= window_neg);
    assign acc        = $signed({i_state.integral_sum[INTEG_W-1], i_state.integral_sum})
                      + ACC_W'(error);
    assign clamp_pos  = $signed({2'b00, i_cfg.integral_clamp});
    assign clamp_neg  = -clamp_pos;

    always_comb begin
        o_state                = i_state;
        o_state.previous_error = error;
        if (!integrate) begin
            o_state.integral_sum = '0;
        end else if (!in_window) begin
            o_state.integral_enable = 1'b0;
        end else begin
            o_state.integral_enable = 1'b1;
            if (acc > clamp_pos) begin
                o_state.integral_sum = clamp_pos[INTEG_W-1:0];
            end else if (acc < clamp_neg) begin
                o_state.integral_sum = clamp_neg[INTEG_W-1:0];
            end else begin
                o_state.integral_sum = acc[INTEG_W-1:0];
            end
        end
    end

endmodule

### rtl/pid_integral_separation_core.sv
// PID controller with integral separation, one drive word per sample word.
//
// Sample channel (s_axis): target, measurement, armed flag and thrust in one
// word. Result channel (m_axis): the saturated sum of the P, I and D terms.
// Config channel: register index and data; index 0..5 selects p_gain,
// i_gain, d_gain, integral_window, integral_clamp, thrust_threshold; other
// indexes are dropped. The config port is always ready and should be written
// only while no sample is in flight.
//
// A sample word is held in the input register, passes through the multiply/add
// logic and is loaded into the output register that drives m_axis.
// Throughput is one word per cycle while the receiver does not stall: the
// input register feeds the multiply/add logic into the output register, and
// the stored error and integral update with it, ready for the next word.
//
// Reset empties both pipeline registers, clears the stored error, integral
// and enable flag, and loads the default gains and limits. When the receiver
// stalls, the output register holds its word and the input register takes
// one more word before s_axis tready drops.
module pid_integral_separation_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // sample word
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [15:0] target, [31:16] measure, [32] armed, [48:33] thrust, [55:49] unused
    input  logic [pisc_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // result word
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [31:0] drive
    output logic [pisc_pkg::DRIVE_W-1:0]       o_m_axis_tdata,
    // config write
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pisc_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [pisc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import pisc_pkg::*;

    t_cfg                 cfg;
    t_item                r_item;
    logic                 r_in_valid;
    logic                 r_out_valid;
    logic [DRIVE_W-1:0]   r_drive;
    t_state               r_state;
    t_state               n_state;
    logic [DRIVE_W-1:0]   n_drive;
    logic                 out_free;
    logic                 advance;
    logic                 s_take;

    pisc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    pisc_calc u_calc (
        .i_cfg   (cfg),
        .i_item  (r_item),
        .i_state (r_state),
        .o_drive (n_drive),
        .o_state (n_state)
    );

    // Handshake: move the input word on when the output slot is free
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign advance         = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;
    assign s_take          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_drive;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_item.target  <= i_s_axis_tdata[15:0];
            r_item.measure <= i_s_axis_tdata[31:16];
            r_item.armed   <= i_s_axis_tdata[32];
            r_item.thrust  <= i_s_axis_tdata[48:33];
        end
    end

    // Output register and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_drive <= n_drive;
        end
    end

endmodule
